@@ rtl/dcdt_pkg.sv @@
`default_nettype none

package dcdt_pkg;

  localparam int unsigned CountWidth = 32;
  localparam int unsigned SrcWidth   = 4;
  localparam int unsigned CfgIdxWidth = 2;

  typedef logic [CountWidth-1:0] count_t;
  typedef logic [SrcWidth-1:0]   src_t;

  // Event source codes
  localparam src_t SRC_CLOCK   = 4'd1;
  localparam src_t SRC_IDLE    = 4'd2;
  localparam src_t SRC_CHAINED = 4'd3;

  // Request function codes
  typedef enum logic [1:0] {
    FUNC_TICK      = 2'd0,
    FUNC_LOAD_LOW  = 2'd1,
    FUNC_LOAD_HIGH = 2'd2,
    FUNC_UNUSED    = 2'd3
  } func_t;

  // Configuration register indexes
  localparam logic [CfgIdxWidth-1:0] REG_LOW_SOURCE  = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_HIGH_SOURCE = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_WRAP_ENABLE = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic       core_idle;
    count_t     load_value;
  } req_t;

  typedef struct packed {
    count_t low_value;
    count_t high_value;
    logic   irq_low;
    logic   irq_high;
  } rsp_t;

  typedef struct packed {
    src_t low_source;
    src_t high_source;
    logic wrap_enable;
  } cfg_t;

  function automatic logic src_ticks(input src_t src, input logic idle);
    logic t;
    t = 1'b0;
    if (src == SRC_CLOCK) begin
      t = 1'b1;
    end else if (src == SRC_IDLE) begin
      t = idle;
    end
    return t;
  endfunction

endpackage

`default_nettype wire

@@ rtl/dcdt_step.sv @@
`default_nettype none

module dcdt_step (
  input  wire dcdt_pkg::cfg_t   cfg,
  input  wire dcdt_pkg::req_t   req,
  input  wire dcdt_pkg::count_t low_counter,
  input  wire dcdt_pkg::count_t high_counter,
  output dcdt_pkg::rsp_t        rsp
);

  logic                  low_tick;
  logic                  high_tick;
  logic                  chained;
  logic [63:0]           pair;
  logic [63:0]           pair_dec;
  dcdt_pkg::count_t      low_dec;
  dcdt_pkg::count_t      high_dec;
  dcdt_pkg::func_t       func;

  assign func      = dcdt_pkg::func_t'(req.func);
  assign low_tick  = dcdt_pkg::src_ticks(cfg.low_source, req.core_idle);
  assign high_tick = dcdt_pkg::src_ticks(cfg.high_source, req.core_idle);
  assign chained   = (cfg.high_source == dcdt_pkg::SRC_CHAINED);

  // Hold at zero unless wrap is enabled
  assign pair     = {high_counter, low_counter};
  assign pair_dec = (pair != 64'd0 || cfg.wrap_enable) ? pair - 64'd1 : pair;
  assign low_dec  = (low_counter != '0 || cfg.wrap_enable) ?
                    low_counter - dcdt_pkg::count_t'(1) : low_counter;
  assign high_dec = (high_counter != '0 || cfg.wrap_enable) ?
                    high_counter - dcdt_pkg::count_t'(1) : high_counter;

  always_comb begin
    rsp.low_value  = low_counter;
    rsp.high_value = high_counter;
    rsp.irq_low    = 1'b0;
    rsp.irq_high   = 1'b0;
    unique case (func)
      dcdt_pkg::FUNC_TICK: begin
        if (low_tick) begin
          if (chained) begin
            rsp.low_value  = pair_dec[31:0];
            rsp.high_value = pair_dec[63:32];
            rsp.irq_low    = (pair_dec == 64'd0);
          end else begin
            rsp.low_value = low_dec;
            rsp.irq_low   = (low_dec == '0);
          end
        end
        // Never set in chained mode, so no clash with the pair update
        if (high_tick) begin
          rsp.high_value = high_dec;
          rsp.irq_high   = (high_dec == '0);
        end
      end
      dcdt_pkg::FUNC_LOAD_LOW: begin
        rsp.low_value = req.load_value;
      end
      dcdt_pkg::FUNC_LOAD_HIGH: begin
        rsp.high_value = req.load_value;
      end
      dcdt_pkg::FUNC_UNUSED: begin
        rsp.low_value = low_counter;
      end
      default: begin
        rsp.low_value = low_counter;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/dual_chainable_down_timer.sv @@
`default_nettype none

// Two 32-bit down counters that can be chained into one 64-bit counter
// (counter 1 as the high half when its source is 3). Each request either
// ticks the counters or loads one of them, and returns both counter values
// plus the two interrupt pulses. One request is taken every cycle while
// the output is not stalled; a request passes through the input register
// and then the result register, with the decrement and zero test between
// them (one 64-bit decrement when chained). Write the configuration
// registers only while no request is in flight.
module dual_chainable_down_timer (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire dcdt_pkg::req_t in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output dcdt_pkg::rsp_t      out_data,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire [dcdt_pkg::CfgIdxWidth-1:0] cfg_index,
  input  wire dcdt_pkg::src_t cfg_data
);

  logic             req_valid;
  dcdt_pkg::req_t   req;
  logic             out_free;
  logic             advance;
  dcdt_pkg::cfg_t   cfg;
  dcdt_pkg::count_t low_counter;
  dcdt_pkg::count_t high_counter;
  dcdt_pkg::rsp_t   rsp_next;

  assign out_free  = !out_valid || !out_stall;
  assign advance   = req_valid && out_free;
  assign in_stall  = req_valid && !out_free;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == dcdt_pkg::REG_LOW_SOURCE) begin
        cfg.low_source <= cfg_data;
      end else if (cfg_index == dcdt_pkg::REG_HIGH_SOURCE) begin
        cfg.high_source <= cfg_data;
      end else if (cfg_index == dcdt_pkg::REG_WRAP_ENABLE) begin
        cfg.wrap_enable <= cfg_data[0];
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req <= in_data;
    end
  end

  dcdt_step u_step (
    .cfg          (cfg),
    .req          (req),
    .low_counter  (low_counter),
    .high_counter (high_counter),
    .rsp          (rsp_next)
  );

  // Counters advance as the request moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      low_counter  <= '0;
      high_counter <= '0;
    end else if (advance) begin
      low_counter  <= rsp_next.low_value;
      high_counter <= rsp_next.high_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= rsp_next;
    end
  end

endmodule

`default_nettype wire
